// ----- hw/rtl/dqts_pkg.sv -----
// Shared types, codes and defaults for the delta-list task timer queue.
`timescale 1ns / 1ps

package dqts_pkg;

  // Default sizing
  localparam int DEF_MAX_TASKS  = 8;
  localparam int DEF_DELAY_BITS = 16;

  // Stream field widths
  localparam int ID_W    = 8;
  localparam int ARG_W   = 16;
  localparam int QCNT_W  = 4;
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 16;

  // Requested operation, carried on s_tuser
  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_TICK     = 2'd1,
    ACT_DISPATCH = 2'd2
  } action_t;

  // Result status
  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_SEARCH,
    ST_SHIFT_UP,
    ST_PLACE,
    ST_POP_HEAD,
    ST_POP_SHIFT,
    ST_REINS,
    ST_FINISH
  } state_t;

endpackage

// ----- hw/rtl/delta_queue_task_scheduler.sv -----
// Delta-list task timer queue with a one-read, one-write entry memory and a small sequencer.
`timescale 1ns / 1ps
//
// Usage:
//   Commands enter on the s_ group; s_tuser selects add, tick or dispatch and s_tdata
//   carries task id, delay and period for an add. Each command gives exactly one result
//   on the m_ group: dispatch flag, task id, status code and the task count after it.
//   One command is worked on at a time; s_tready is high only while the sequencer idles.
//   Steps from accept to result valid (N = tasks held):
//     tick: one head read, then one update.
//     add: the search compares entries, the entries behind the slot move up, then placement.
//     dispatch: head read, N - 1 entries moved down, reload check; a reload
//     adds the search, moves and placement of an add.
//     full-queue add, empty or ignored tick, idle dispatch, unused code: straight to the result.
//   The walk is bound by the entry memory: one read and one write per cycle, so the
//   search and the moves walk the queue one entry a cycle.
//   The result sits in an output register; if the receiver stalls, it waits there and
//   the next finished command holds the sequencer in its last state until the slot frees.
//   Reset (rst, synchronous) empties the queue and clears the due flag; the entry memory
//   itself is not cleared, since only entries below the count are ever used.
//
module delta_queue_task_scheduler #(
  parameter int MAX_TASKS  = dqts_pkg::DEF_MAX_TASKS,
  parameter int DELAY_BITS = dqts_pkg::DEF_DELAY_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tuser: action[1:0]
  // s_tdata: new_task_id[7:0], new_delay[23:8], new_period[39:24]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [1:0]                    s_tuser,
  input  logic [dqts_pkg::S_DATA_W-1:0] s_tdata,
  // m_tuser: run_valid
  // m_tdata: run_task_id[7:0], status[9:8], queue_count[13:10], zero[15:14]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          m_tuser,
  output logic [dqts_pkg::M_DATA_W-1:0] m_tdata
);
  import dqts_pkg::*;

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int DB    = DELAY_BITS;

  // Entry memory
  logic [ID_W-1:0] mem_id     [MAX_TASKS];
  logic [DB-1:0]   mem_delta  [MAX_TASKS];
  logic [DB-1:0]   mem_period [MAX_TASKS];

  logic [IDX_W-1:0] rd_addr;
  logic [ID_W-1:0]  rd_id;
  logic [DB-1:0]    rd_delta;
  logic [DB-1:0]    rd_period;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ID_W-1:0]  wr_id;
  logic [DB-1:0]    wr_delta;
  logic [DB-1:0]    wr_period;

  // Control and working registers
  state_t           state, state_next;
  logic [CNT_W-1:0] count;
  logic             head_due;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] k;
  logic [DB-1:0]    cum;
  logic [DB-1:0]    nd;
  logic [ID_W-1:0]  new_id;
  logic [DB-1:0]    new_delay;
  logic [DB-1:0]    new_period;
  logic             res_valid;
  logic [ID_W-1:0]  res_id;
  err_t             res_err;

  action_t          act;
  logic [DB:0]      sum;
  logic             less;
  logic [DB-1:0]    nd_calc;
  logic             out_free;

  assign act      = action_t'(s_tuser);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Shared adder and compare for the search walk
  assign sum     = {1'b0, cum} + {1'b0, rd_delta};
  assign less    = sum < {1'b0, new_delay};
  assign nd_calc = new_delay - cum;

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]     <= wr_id;
      mem_delta[wr_addr]  <= wr_delta;
      mem_period[wr_addr] <= wr_period;
    end
    rd_id     <= mem_id[rd_addr];
    rd_delta  <= mem_delta[rd_addr];
    rd_period <= mem_period[rd_addr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (act)
            ACT_ADD: begin
              if (count == CNT_W'(MAX_TASKS)) state_next = ST_FINISH;
              else if (CNT_W'(head_due) == count) state_next = ST_PLACE;
              else state_next = ST_SEARCH;
            end
            ACT_TICK: begin
              if (count == '0 || head_due) state_next = ST_FINISH;
              else state_next = ST_TICK;
            end
            ACT_DISPATCH: begin
              if (head_due) state_next = ST_POP_HEAD;
              else state_next = ST_FINISH;
            end
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_TICK: state_next = ST_FINISH;
      ST_SEARCH: begin
        if (less) begin
          if (CNT_W'(idx) + CNT_W'(1) == count) state_next = ST_PLACE;
        end else begin
          state_next = ST_SHIFT_UP;
        end
      end
      ST_SHIFT_UP: begin
        if (k - IDX_W'(1) == idx) state_next = ST_PLACE;
      end
      ST_PLACE: state_next = ST_FINISH;
      ST_POP_HEAD: begin
        if (count == CNT_W'(1)) state_next = ST_REINS;
        else state_next = ST_POP_SHIFT;
      end
      ST_POP_SHIFT: begin
        if (CNT_W'(k) + CNT_W'(1) == count) state_next = ST_REINS;
      end
      ST_REINS: begin
        if (new_period == '0) state_next = ST_FINISH;
        else if (count == '0) state_next = ST_PLACE;
        else state_next = ST_SEARCH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory addressing and write data per state
  always_comb begin
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = idx;
    wr_id     = rd_id;
    wr_delta  = rd_delta;
    wr_period = rd_period;
    unique case (state)
      ST_IDLE: begin
        // add behind a due head starts its walk at entry one
        if (act == ACT_ADD && head_due) rd_addr = IDX_W'(1);
      end
      ST_TICK: begin
        if (rd_delta != '0) begin
          wr_en    = 1'b1;
          wr_addr  = '0;
          wr_delta = rd_delta - DB'(1);
        end
      end
      ST_SEARCH: begin
        if (less) rd_addr = idx + IDX_W'(1);
        else rd_addr = IDX_W'(count - CNT_W'(1));
      end
      ST_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = k;
        // successor of the new entry loses the new delta
        if (k - IDX_W'(1) == idx) wr_delta = rd_delta - nd;
        rd_addr = k - IDX_W'(2);
      end
      ST_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = idx;
        wr_id     = new_id;
        wr_delta  = nd_calc;
        wr_period = new_period;
      end
      ST_POP_HEAD: rd_addr = IDX_W'(1);
      ST_POP_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = k;
        rd_addr = k + IDX_W'(2);
      end
      ST_REINS: rd_addr = '0;
      ST_FINISH: rd_addr = '0;
      default: rd_addr = '0;
    endcase
  end

  // State, queue bookkeeping and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      head_due <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // result slot: loaded on finish, freed once taken
      if (state == ST_FINISH && out_free) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            new_id     <= s_tdata[7:0];
            new_delay  <= DB'(s_tdata[23:8]);
            new_period <= DB'(s_tdata[39:24]);
            cum        <= '0;
            idx        <= (act == ACT_ADD && head_due) ? IDX_W'(1) : '0;
            res_valid  <= 1'b0;
            res_id     <= '0;
            res_err    <= ERR_NONE;
            if (act == ACT_ADD && count == CNT_W'(MAX_TASKS)) res_err <= ERR_FULL;
            if (act == ACT_TICK && count == '0) res_err <= ERR_EMPTY;
          end
        end
        ST_TICK: begin
          if (rd_delta == '0) head_due <= 1'b1;
        end
        ST_SEARCH: begin
          if (less) begin
            cum <= sum[DB-1:0];
            idx <= idx + IDX_W'(1);
          end else begin
            nd <= nd_calc;
            k  <= IDX_W'(count);
          end
        end
        ST_SHIFT_UP: k <= k - IDX_W'(1);
        ST_PLACE: count <= count + CNT_W'(1);
        ST_POP_HEAD: begin
          res_valid  <= 1'b1;
          res_id     <= rd_id;
          new_id     <= rd_id;
          new_delay  <= rd_period;
          new_period <= rd_period;
          head_due   <= 1'b0;
          count      <= count - CNT_W'(1);
          k          <= '0;
        end
        ST_POP_SHIFT: k <= k + IDX_W'(1);
        ST_REINS: begin
          cum <= '0;
          idx <= '0;
        end
        ST_FINISH: begin
          if (out_free) begin
            m_tuser  <= res_valid;
            m_tdata  <= {2'b00, QCNT_W'(count), res_err, res_id};
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // Queue never holds more than its capacity
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_TASKS))
    else $error("task count above capacity");

  // A due head implies a nonempty queue
  a_due_nonempty: assert property (@(posedge clk) disable iff (rst)
    head_due |-> count != '0)
    else $error("head due on empty queue");

  // Search walk stays within the held entries
  a_search_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |-> CNT_W'(idx) < count)
    else $error("search beyond held entries");

  // Memory is left alone while idle or waiting on the receiver
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_FINISH) |-> !wr_en)
    else $error("entry write outside a command");

  // A dispatched task never carries an error
  a_run_no_err: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tdata[9:8] == ERR_NONE)
    else $error("dispatch result with error code");
`endif

endmodule
